FILE: rtl/bmpp_pkg.sv
// Package for the BMP pixel array packer.
// Holds sizes, register indexes and the command and status types that the
// front, queue and back modules share. Depends on nothing.
`default_nettype none

package bmpp_pkg;

    // Image bounds and the counter widths they set
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Configuration register widths and reset values
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam int THRESH_W    = 9;
    localparam int DIM_W       = 13;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(128);
    localparam logic [DIM_W-1:0]    DIM_RESET    = DIM_W'(1);

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BITS_MODE    = 2'd0,
        REG_THRESHOLD    = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } bmpp_reg_t;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One command: a data byte, then pads zero bytes
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_col;
        logic       last_row;
        logic [1:0] pads;
    } bmpp_cmd_t;

    // Queue fill status
    typedef struct packed {
        logic             full;
        logic             empty;
        logic [FIFO_AW:0] count;
    } bmpp_fifo_stat_t;

endpackage : bmpp_pkg

`default_nettype wire

FILE: rtl/bmpp_front.sv
// Front part of the BMP pixel array packer: configuration registers, pixel
// accept, row and column counting, 1-bit packing and pad count.
// Depends on bmpp_pkg.
`default_nettype none

module bmpp_front
    import bmpp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   pix_valid,
    output logic                        pix_ready,
    input  wire logic [7:0]             pixel,
    input  wire bmpp_fifo_stat_t        fifo_stat,
    output logic                        push,
    output bmpp_cmd_t                   push_cmd
);

    logic                bits_mode_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;

    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [7:0]          acc_reg, acc_next;
    logic [2:0]          pos_reg, pos_next;

    logic [COL_W-1:0]    width_m1;
    logic [ROW_W-1:0]    height_m1;
    logic [COL_W+2:0]    wm1_ext;
    logic [1:0]          row_bytes_low;
    logic                accept;
    logic                last_col;
    logic                last_row;
    logic                bit_val;
    logic [7:0]          acc_merged;
    logic                emit;

    // Clamp dimensions to 1..MAX and keep them minus one
    always_comb
    begin
        if (image_width_reg == '0)
            width_m1 = '0;
        else if (32'(image_width_reg) > MAX_WIDTH)
            width_m1 = COL_W'(MAX_WIDTH - 1);
        else
            width_m1 = COL_W'(image_width_reg - DIM_W'(1));

        if (image_height_reg == '0)
            height_m1 = '0;
        else if (32'(image_height_reg) > MAX_HEIGHT)
            height_m1 = ROW_W'(MAX_HEIGHT - 1);
        else
            height_m1 = ROW_W'(image_height_reg - DIM_W'(1));
    end

    // Classify the pixel and build its command
    always_comb
    begin
        accept     = pix_valid && pix_ready;
        last_col   = col_reg >= width_m1;
        last_row   = row_reg >= height_m1;
        wm1_ext    = (COL_W+3)'(width_m1);
        bit_val    = {1'b0, pixel} >= threshold_reg;
        acc_merged = acc_reg | (8'(bit_val) << (3'd7 - pos_reg));

        if (bits_mode_reg)
        begin
            // bytes per row = floor((width - 1) / 8) + 1
            row_bytes_low = 2'(wm1_ext >> 3) + 2'd1;
            emit          = last_col || (pos_reg == 3'd7);
        end
        else
        begin
            row_bytes_low = 2'(wm1_ext) + 2'd1;
            emit          = 1'b1;
        end

        push_cmd.data_byte = bits_mode_reg ? acc_merged : pixel;
        push_cmd.last_col  = last_col;
        push_cmd.last_row  = last_row;
        push_cmd.pads      = last_col ? (2'd0 - row_bytes_low) : 2'd0;

        push = accept && emit;
    end

    assign pix_ready = !fifo_stat.full;

    // Next counter and packing state
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
            if (bits_mode_reg)
            begin
                if (emit)
                begin
                    acc_next = '0;
                    pos_next = '0;
                end
                else
                begin
                    acc_next = acc_merged;
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    // Hold configuration; any write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_mode_reg    <= 1'b0;
            threshold_reg    <= THRESH_RESET;
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
            col_reg          <= '0;
            row_reg          <= '0;
            acc_reg          <= '0;
            pos_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bmpp_reg_t'(cfg_index))
                REG_BITS_MODE:    bits_mode_reg    <= cfg_data[0];
                REG_THRESHOLD:    threshold_reg    <= cfg_data[THRESH_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default:          bits_mode_reg    <= bits_mode_reg;
            endcase
            col_reg <= '0;
            row_reg <= '0;
            acc_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

endmodule : bmpp_front

`default_nettype wire

FILE: rtl/bmpp_fifo.sv
// Short command queue between the front and back of the packer.
// Register-based, first word shown at the head without a read delay.
// Depends on bmpp_pkg.
`default_nettype none

module bmpp_fifo
    import bmpp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire bmpp_cmd_t push_cmd,
    input  wire logic      pop,
    output bmpp_cmd_t      head,
    output bmpp_fifo_stat_t stat
);

    bmpp_cmd_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    always_comb
    begin
        stat.full  = count_reg == (FIFO_AW+1)'(FIFO_DEPTH);
        stat.empty = count_reg == '0;
        stat.count = count_reg;
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        head       = mem[rd_ptr_reg];
    end

    // Store incoming commands
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == FIFO_DEPTH - 1) ? '0
                                                                  : wr_ptr_reg + FIFO_AW'(1);
            if (do_pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == FIFO_DEPTH - 1) ? '0
                                                                  : rd_ptr_reg + FIFO_AW'(1);
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (FIFO_AW+1)'(1);
                2'b01:   count_reg <= count_reg - (FIFO_AW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule : bmpp_fifo

`default_nettype wire

FILE: rtl/bmpp_back.sv
// Back part of the packer: expands each command into its data byte and pad
// bytes, one word per cycle unless stalled, via a registered output stage.
// Depends on bmpp_pkg.
`default_nettype none

module bmpp_back
    import bmpp_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bmpp_cmd_t       head,
    input  wire bmpp_fifo_stat_t fifo_stat,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           data_byte,
    output logic                 row_end,
    output logic                 frame_end,
    output logic                 run_last
);

    logic       out_valid_reg;
    logic [7:0] data_reg, data_next;
    logic       row_end_reg, row_end_next;
    logic       frame_end_reg, frame_end_next;
    logic       run_last_reg, run_last_next;
    logic       in_pads_reg, in_pads_next;
    logic [1:0] pad_left_reg, pad_left_next;
    logic       advance;
    logic       fire;
    logic       ends;

    // Pick the next word from the queue head
    always_comb
    begin
        advance        = !out_valid_reg || out_ready;
        fire           = advance && !fifo_stat.empty;
        in_pads_next   = in_pads_reg;
        pad_left_next  = pad_left_reg;
        pop            = 1'b0;
        if (!in_pads_reg)
        begin
            ends           = head.pads == 2'd0;
            data_next      = head.data_byte;
            row_end_next   = head.last_col && ends;
            frame_end_next = head.last_col && ends && head.last_row;
            run_last_next  = ends;
            if (fire)
            begin
                pop           = ends;
                in_pads_next  = !ends;
                pad_left_next = head.pads;
            end
        end
        else
        begin
            ends           = pad_left_reg == 2'd1;
            data_next      = 8'd0;
            row_end_next   = ends;
            frame_end_next = ends && head.last_row;
            run_last_next  = ends;
            if (fire)
            begin
                pop           = ends;
                in_pads_next  = !ends;
                pad_left_next = pad_left_reg - 2'd1;
            end
        end
    end

    // Hold output word until taken; advance pad state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            in_pads_reg   <= 1'b0;
            pad_left_reg  <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
            in_pads_reg   <= in_pads_next;
            pad_left_reg  <= pad_left_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            data_reg      <= data_next;
            row_end_reg   <= row_end_next;
            frame_end_reg <= frame_end_next;
            run_last_reg  <= run_last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_byte = data_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;
    assign run_last  = run_last_reg;

endmodule : bmpp_back

`default_nettype wire

FILE: rtl/bmp_pixel_array_packer_top.sv
// Top level of the BMP pixel array packer: front, command queue and back.
// Depends on bmpp_pkg, bmpp_front, bmpp_fifo and bmpp_back.
//
//   Channel   Dir  Handshake                   Contents
//   s_axis    in   s_axis_tvalid/tready        tdata[7:0] = pixel
//   m_axis    out  m_axis_tvalid/tready        tdata[7:0] = data_byte,
//                                              tuser = {frame_end, row_end},
//                                              tlast = run_last
//   cfg       in   cfg_we                      cfg_index, cfg_data
//
// One pixel is taken per cycle while the queue has room; the back sends
// one byte per cycle while m_axis is ready, so a row-ending pixel with
// padding makes up to four bytes. A four-entry command queue absorbs those
// bursts; the front stalls only when it is full. Reset clears counters, the
// queue and the output stage, and loads the register reset values. A stalled
// m_axis holds its word and fills the queue.
`default_nettype none

module bmp_pixel_array_packer_top
    import bmpp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] pixel
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]                  m_axis_tuser,   // [0] row_end, [1] frame_end
    output logic                        m_axis_tlast
);

    bmpp_cmd_t       push_cmd;
    bmpp_cmd_t       head;
    bmpp_fifo_stat_t fifo_stat;
    logic            push;
    logic            pop;

    bmpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (s_axis_tvalid),
        .pix_ready (s_axis_tready),
        .pixel     (s_axis_tdata),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    bmpp_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    bmpp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .data_byte (m_axis_tdata),
        .row_end   (m_axis_tuser[0]),
        .frame_end (m_axis_tuser[1]),
        .run_last  (m_axis_tlast)
    );

    // Queue never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(fifo_stat.count) <= FIFO_DEPTH)
        else $error("command queue overfilled");

    // A frame end is always a row end
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("frame end without row end");

    // A row end closes the words of its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("row end not on last word of pixel");

endmodule : bmp_pixel_array_packer_top

`default_nettype wire

FILE: tb/tb_bmp_pixel_array_packer_top.sv
// Testbench for bmp_pixel_array_packer_top: streams grey pixels under many register
// settings and checks every output word against a built-in packing predictor.
// Depends on bmpp_pkg and the packer RTL only.
`timescale 1ns / 100ps

module tb_bmp_pixel_array_packer_top
    import bmpp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 100;
    localparam int FINAL_PIXELS  = 8;

    // One byte of the pixel array as it leaves the block
    typedef struct packed {
        logic [7:0] data_byte;
        logic       row_end;
        logic       frame_end;
        logic       run_last;
    } array_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_BITS_MODE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [7:0]             m_axis_tdata;
    logic [1:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    bmp_pixel_array_packer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Predictor copy of the registers and the packing state
    logic        mode_1bpp;
    logic [8:0]  thresh_r;
    logic [12:0] width_r;
    logic [12:0] height_r;
    logic [11:0] col_cnt;
    logic [11:0] row_cnt;
    logic [7:0]  bit_acc;
    logic [2:0]  bit_pos;

    array_word_t pending_words[$];
    logic [7:0]  pixel_q[$];

    int  cycles = 0;
    int  errors = 0;
    int  pixels_taken = 0;
    int  words_checked = 0;
    int  rows_closed = 0;
    int  frames_closed = 0;
    int  settings_used = 0;
    bit  steady;
    bit  pix_busy = 1'b0;
    bit  pix_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    // Most gaps short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    function automatic logic [12:0] clamp_dim(input logic [12:0] v, input int lim);
        if (v == 13'd0)
            return 13'd1;
        if (int'(v) > lim)
            return 13'(lim);
        return v;
    endfunction

    // Bias pixels toward the threshold edge in 1-bit mode
    function automatic logic [7:0] pick_pixel();
        int v;
        if (mode_1bpp && $urandom_range(99) < 35) begin
            v = int'(thresh_r) + $urandom_range(0, 2) - 1;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return 8'(v);
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic restart_frame();
        col_cnt = '0;
        row_cnt = '0;
        bit_acc = '0;
        bit_pos = '0;
    endtask

    // Expected words for one accepted pixel
    task automatic pack_pixel(input logic [7:0] pix);
        logic [12:0] w;
        logic [12:0] h;
        logic        last_col;
        logic        last_row;
        logic        emit;
        logic        bit_val;
        logic [7:0]  out_val;
        logic [13:0] row_bytes;
        logic [1:0]  pads;
        array_word_t burst[$];
        array_word_t word;
        w = clamp_dim(width_r, MAX_WIDTH);
        h = clamp_dim(height_r, MAX_HEIGHT);
        last_col = (14'(col_cnt) + 14'd1) >= 14'(w);
        last_row = (14'(row_cnt) + 14'd1) >= 14'(h);
        if (!mode_1bpp) begin
            emit = 1'b1;
            out_val = pix;
            row_bytes = 14'(w);
        end
        else begin
            bit_val = ({1'b0, pix} >= thresh_r);
            bit_acc = bit_acc | (8'(bit_val) << (3'd7 - bit_pos));
            emit = last_col || (bit_pos == 3'd7);
            out_val = bit_acc;
            if (emit) begin
                bit_acc = '0;
                bit_pos = '0;
            end
            else begin
                bit_pos = bit_pos + 3'd1;
            end
            row_bytes = (14'(w) + 14'd7) >> 3;
        end
        pads = last_col ? 2'(3'd4 - {1'b0, row_bytes[1:0]}) : 2'd0;
        if (emit) begin
            word.data_byte = out_val;
            word.row_end = last_col && (pads == 2'd0);
            word.frame_end = word.row_end && last_row;
            word.run_last = 1'b0;
            burst.push_back(word);
        end
        for (int i = 0; i < int'(pads); i++) begin
            word.data_byte = 8'd0;
            word.row_end = (i + 1 == int'(pads));
            word.frame_end = word.row_end && last_row;
            word.run_last = 1'b0;
            burst.push_back(word);
        end
        if (burst.size() > 0)
            burst[burst.size()-1].run_last = 1'b1;
        foreach (burst[k])
            pending_words.push_back(burst[k]);
        if (last_col) begin
            col_cnt = '0;
            row_cnt = last_row ? 12'd0 : row_cnt + 12'd1;
        end
        else begin
            col_cnt = col_cnt + 12'd1;
        end
    endtask

    task automatic report_mismatch(input string field, input int exp_v, input int act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endtask

    // Write one register while the block is idle and mirror it
    task automatic write_reg(input bmpp_reg_t idx, input logic [12:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_BITS_MODE:    mode_1bpp = val[0];
            REG_THRESHOLD:    thresh_r = val[8:0];
            REG_IMAGE_WIDTH:  width_r = val;
            REG_IMAGE_HEIGHT: height_r = val;
            default:          ;
        endcase
        restart_frame();
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Hold until every pixel is in and every word is out, then let the pipe drain
    task automatic wait_idle();
        while (pixel_q.size() != 0 || pix_busy || pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        settings_used++;
    endtask

    // Cycle count, steady stretches without idling, and the watchdog
    always @(posedge clk) begin
        cycles++;
        steady = (cycles % 400) >= 320;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("** bmp_pixel_array_packer_top: FAILED **");
            $finish;
        end
    end

    // Pixel driver: advance on acceptance, insert random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!pix_busy || pix_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                pix_busy = 1'b0;
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_q.size() > 0) begin
                s_axis_tdata <= pixel_q.pop_front();
                s_axis_tvalid <= 1'b1;
                pix_busy = 1'b1;
                gap_left = steady ? 0 : pick_gap();
            end
            else begin
                pix_busy = 1'b0;
                s_axis_tvalid <= 1'b0;
            end
        end
        pix_taken = 1'b0;
    end

    // Output back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!steady && $urandom_range(99) < 30) begin
            stall_left = pick_gap();
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted pixel, check each accepted output word
    always @(posedge clk) begin
        array_word_t want;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                pack_pixel(s_axis_tdata);
                pix_taken = 1'b1;
                pixels_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_words.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, actual data %0d tuser %b tlast %b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else begin
                    want = pending_words.pop_front();
                    words_checked++;
                    if (m_axis_tdata !== want.data_byte)
                        report_mismatch("data_byte", want.data_byte, m_axis_tdata);
                    if (m_axis_tuser[0] !== want.row_end)
                        report_mismatch("row_end", want.row_end, m_axis_tuser[0]);
                    if (m_axis_tuser[1] !== want.frame_end)
                        report_mismatch("frame_end", want.frame_end, m_axis_tuser[1]);
                    if (m_axis_tlast !== want.run_last)
                        report_mismatch("run_last", want.run_last, m_axis_tlast);
                    if (want.row_end)
                        rows_closed++;
                    if (want.frame_end)
                        frames_closed++;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        int          r;
        int          n;
        int          frame_px;
        int          random_sent;
        logic [3:0]  touch;
        logic [12:0] val;
        logic [7:0]  thr_px [10];

        mode_1bpp = 1'b0;
        thresh_r = THRESH_RESET;
        width_r = DIM_RESET;
        height_r = DIM_RESET;
        restart_frame();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: 8-bit, one-pixel image, three pad bytes per row
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        pixel_q.push_back(8'h7F);
        pixel_q.push_back(8'h80);
        wait_idle();

        // Zero width and height act as one; zero threshold sets every bit
        write_reg(REG_BITS_MODE, 13'd1);
        write_reg(REG_THRESHOLD, 13'd0);
        write_reg(REG_IMAGE_WIDTH, 13'd0);
        write_reg(REG_IMAGE_HEIGHT, 13'd0);
        pixel_q.push_back(8'h00);
        pixel_q.push_back(8'hFF);
        wait_idle();

        // Threshold edge, partial last byte, one row of a two-row frame
        write_reg(REG_THRESHOLD, 13'd128);
        write_reg(REG_IMAGE_WIDTH, 13'd10);
        write_reg(REG_IMAGE_HEIGHT, 13'd2);
        thr_px = '{8'd127, 8'd128, 8'd0, 8'd255, 8'd129, 8'd1, 8'd200, 8'd100,
                   8'd128, 8'd127};
        foreach (thr_px[i])
            pixel_q.push_back(thr_px[i]);
        wait_idle();

        // Threshold above 255: no pixel reaches it
        write_reg(REG_THRESHOLD, 13'd256);
        write_reg(REG_IMAGE_WIDTH, 13'd5);
        repeat (5) pixel_q.push_back(8'hFF);
        wait_idle();

        // Random settings, whole frames or cut-off runs
        random_sent = 0;
        while (random_sent < RANDOM_PIXELS) begin
            touch = 4'($urandom_range(1, 15));
            if (touch[0])
                write_reg(REG_BITS_MODE, 13'($urandom));
            if (touch[1]) begin
                r = $urandom_range(99);
                if (r < 12)
                    val = 13'd0;
                else if (r < 22)
                    val = 13'd256;
                else if (r < 30)
                    val = 13'($urandom);
                else if (r < 36)
                    val = 13'd255;
                else
                    val = 13'($urandom_range(1, 255));
                write_reg(REG_THRESHOLD, val);
            end
            if (touch[2]) begin
                r = $urandom_range(99);
                if (r < 8)
                    val = 13'd0;
                else if (r < 13)
                    val = 13'h1FFF;
                else if (r < 17)
                    val = 13'($urandom);
                else
                    val = 13'($urandom_range(1, 20));
                write_reg(REG_IMAGE_WIDTH, val);
            end
            if (touch[3]) begin
                r = $urandom_range(99);
                if (r < 10)
                    val = 13'd0;
                else if (r < 16)
                    val = 13'h1FFF;
                else
                    val = 13'($urandom_range(1, 4));
                write_reg(REG_IMAGE_HEIGHT, val);
            end
            frame_px = int'(clamp_dim(width_r, MAX_WIDTH)) * int'(clamp_dim(height_r, MAX_HEIGHT));
            if (frame_px <= 24 && $urandom_range(99) < 60)
                n = frame_px * $urandom_range(1, 2);
            else
                n = $urandom_range(1, 24);
            if (n > RANDOM_PIXELS - random_sent)
                n = RANDOM_PIXELS - random_sent;
            repeat (n) pixel_q.push_back(pick_pixel());
            random_sent += n;
            wait_idle();
        end

        // A cut-off row at the saturated width in 1-bit mode
        write_reg(REG_BITS_MODE, 13'd1);
        write_reg(REG_THRESHOLD, 13'($urandom_range(1, 255)));
        write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 13'd1);
        repeat (FINAL_PIXELS) pixel_q.push_back(pick_pixel());
        wait_idle();

        $display("Covered %0d pixels over %0d register settings, both pixel modes and clamped sizes",
                 pixels_taken, settings_used);
        $display("Checked %0d output words, %0d row ends and %0d frame ends",
                 words_checked, rows_closed, frames_closed);
        if (errors == 0 && pending_words.size() == 0)
            $display("** bmp_pixel_array_packer_top: PASSED **");
        else
            $display("** bmp_pixel_array_packer_top: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
rtl/bmpp_pkg.sv
rtl/bmpp_front.sv
rtl/bmpp_fifo.sv
rtl/bmpp_back.sv
rtl/bmp_pixel_array_packer_top.sv
tb/tb_bmp_pixel_array_packer_top.sv
